@@ hdl/rgb_led_matrix_scan_controller_unit_assert.svh @@
// ----------------------------------------------------------------------------
// rgb_led_matrix_scan_controller_unit_assert.svh
// Assertion macros for the LED matrix scan controller, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_MATRIX_SCAN_CONTROLLER_UNIT_ASSERT_SVH
`define RGB_LED_MATRIX_SCAN_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication
`define RLMSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLMSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rlmsc_pkg.sv @@
// ----------------------------------------------------------------------------
// rlmsc_pkg
// Shared types, constants and helpers of the LED matrix scan controller.
// ----------------------------------------------------------------------------
package rlmsc_pkg;

  localparam int unsigned FRAME_BYTES    = 24;
  localparam int unsigned DEF_MAX_FRAMES = 16;
  localparam int unsigned DEF_LEVELS     = 16;
  localparam logic [2:0]  LAST_ROW       = 3'd7;
  localparam logic [1:0]  LAST_BYTE      = 2'd2;
  localparam logic [4:0]  FRAMES_RESET   = 5'd1;

  typedef enum logic [2:0] {
    CMD_WR_BYTE    = 3'd0,
    CMD_WR_LINE    = 3'd1,
    CMD_WR_PIXEL   = 3'd2,
    CMD_SEL_FRAME  = 3'd3,
    CMD_NEXT_FRAME = 3'd4,
    CMD_RESTART    = 3'd5,
    CMD_DRAW       = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_TAKE
  } state_e;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic mem_wr;
    logic k_inc;
    logic take;
    logic emit;
    cmd_e op;
  } ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic wr_ok;
    logic clr_done;
    logic k_last;
  } stat_t;

  function automatic logic [7:0] row_drive(input logic [2:0] row);
    logic [7:0] drv;
    if (row < 3'd3) begin
      drv = 8'h04 >> row;
    end else begin
      drv = 8'h80 >> (row - 3'd3);
    end
    return drv;
  endfunction

endpackage

@@ hdl/rlmsc_ram.sv @@
// ----------------------------------------------------------------------------
// rlmsc_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rlmsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 384,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/rlmsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// rlmsc_ctrl
// Sequencer: store clearing after reset, byte and line writes, read-modify-write of
// pixels and the three-byte row read of a draw.
// ----------------------------------------------------------------------------
module rlmsc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  rlmsc_pkg::stat_t stat_i,
  output rlmsc_pkg::ctrl_t ctrl_o,
  output logic             busy_o
);

  rlmsc_pkg::state_e state_q, state_d;
  rlmsc_pkg::cmd_e   op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rlmsc_pkg::ST_CLEAR;
      op_q    <= rlmsc_pkg::CMD_WR_BYTE;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    ctrl_o        = '0;
    ctrl_o.op     = op_q;
    busy_o        = 1'b1;
    unique case (state_q)
      rlmsc_pkg::ST_CLEAR: begin
        ctrl_o.clr_wr = 1'b1;
        if (stat_i.clr_done) begin
          state_d = rlmsc_pkg::ST_IDLE;
        end
      end
      rlmsc_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctrl_o.load = 1'b1;
          op_d        = stat_i.cmd;
          case (stat_i.cmd) inside
            rlmsc_pkg::CMD_WR_BYTE, rlmsc_pkg::CMD_WR_LINE: begin
              if (stat_i.wr_ok) begin
                state_d = rlmsc_pkg::ST_WRITE;
              end
            end
            rlmsc_pkg::CMD_WR_PIXEL: begin
              if (stat_i.wr_ok) begin
                state_d = rlmsc_pkg::ST_READ;
              end
            end
            rlmsc_pkg::CMD_DRAW: begin
              state_d = rlmsc_pkg::ST_READ;
            end
            default: begin
              state_d = rlmsc_pkg::ST_IDLE;
            end
          endcase
        end
      end
      rlmsc_pkg::ST_WRITE: begin
        ctrl_o.mem_wr = 1'b1;
        if (op_q == rlmsc_pkg::CMD_WR_BYTE || stat_i.k_last) begin
          state_d = rlmsc_pkg::ST_IDLE;
        end else begin
          ctrl_o.k_inc = 1'b1;
        end
      end
      rlmsc_pkg::ST_READ: begin
        state_d = rlmsc_pkg::ST_TAKE;
      end
      rlmsc_pkg::ST_TAKE: begin
        ctrl_o.mem_wr = (op_q == rlmsc_pkg::CMD_WR_PIXEL);
        ctrl_o.take   = (op_q == rlmsc_pkg::CMD_DRAW);
        if (stat_i.k_last) begin
          ctrl_o.emit = (op_q == rlmsc_pkg::CMD_DRAW);
          state_d     = rlmsc_pkg::ST_IDLE;
        end else begin
          ctrl_o.k_inc = 1'b1;
          state_d      = rlmsc_pkg::ST_READ;
        end
      end
      default: begin
        state_d = rlmsc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/rlmsc_dp.sv @@
// ----------------------------------------------------------------------------
// rlmsc_dp
// Datapath: frame store, scan and frame registers, address generation,
// byte and pixel update, shift word assembly and result registers.
// ----------------------------------------------------------------------------
module rlmsc_dp #(
  parameter int unsigned MAX_FRAMES = rlmsc_pkg::DEF_MAX_FRAMES,
  parameter int unsigned LEVELS     = rlmsc_pkg::DEF_LEVELS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [2:0]       command_i,
  input  logic [3:0]       frame_number_i,
  input  logic [4:0]       byte_index_i,
  input  logic [2:0]       bit_position_i,
  input  logic [7:0]       data_byte_i,
  input  logic [7:0]       red_value_i,
  input  logic [7:0]       green_value_i,
  input  logic [7:0]       blue_value_i,
  input  logic [4:0]       brightness_level_i,
  input  logic             cfg_we_i,
  input  logic [4:0]       cfg_wdata_i,
  input  rlmsc_pkg::ctrl_t ctrl_i,
  output rlmsc_pkg::stat_t stat_o,
  output logic             done_o,
  output logic [7:0]       row_drive_o,
  output logic [23:0]      shift_word_o,
  output logic [2:0]       row_number_o
);

  localparam int unsigned DEPTH = MAX_FRAMES * rlmsc_pkg::FRAME_BYTES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned FW    = ($clog2(MAX_FRAMES) > 4) ? $clog2(MAX_FRAMES) : 4;
  localparam int unsigned CW    = FW + 5;
  localparam int unsigned PW    = $clog2(LEVELS);

  rlmsc_pkg::cmd_e cmd;
  logic [4:0]      fiu_q;
  logic [FW-1:0]   shown_q;
  logic [2:0]      row_q;
  logic [PW-1:0]   phase_q;
  logic [AW-1:0]   clr_q;
  logic [CW-1:0]   base_q, base_d;
  logic [1:0]      k_q;
  logic [2:0]      bit_q;
  logic [7:0]      data_q, red_q, green_q, blue_q;
  logic [4:0]      level_q;
  logic [15:0]     word_q;
  logic            done_q;
  logic [7:0]      row_drive_q;
  logic [23:0]     shift_q;
  logic [2:0]      row_num_q;

  logic [7:0]      eff;
  logic [7:0]      shown_inc;
  logic            frame_ok, idx_ok_byte, idx_ok_line;
  logic [AW-1:0]   addr;
  logic [7:0]      rdata, wdata, colour, mask;
  logic            we, show;
  logic [23:0]     word;

  assign cmd         = rlmsc_pkg::cmd_e'(command_i);
  assign eff         = (8'(fiu_q) > 8'(MAX_FRAMES)) ? 8'(MAX_FRAMES) : 8'(fiu_q);
  assign frame_ok    = 8'(frame_number_i) < eff;
  assign idx_ok_byte = byte_index_i < 5'(rlmsc_pkg::FRAME_BYTES);
  assign idx_ok_line = (6'(byte_index_i) + 6'd2) < 6'(rlmsc_pkg::FRAME_BYTES);
  assign shown_inc   = 8'(shown_q) + 8'd1;

  always_comb begin
    stat_o          = '0;
    stat_o.cmd      = cmd;
    stat_o.clr_done = (clr_q == AW'(DEPTH - 1));
    stat_o.k_last   = (k_q == rlmsc_pkg::LAST_BYTE);
    unique case (cmd) inside
      rlmsc_pkg::CMD_WR_BYTE: stat_o.wr_ok = frame_ok && idx_ok_byte;
      rlmsc_pkg::CMD_WR_LINE, rlmsc_pkg::CMD_WR_PIXEL: begin
        stat_o.wr_ok = frame_ok && idx_ok_line;
      end
      default: stat_o.wr_ok = 1'b0;
    endcase
  end

  always_comb begin
    if (cmd == rlmsc_pkg::CMD_DRAW) begin
      base_d = CW'(shown_q) * CW'(rlmsc_pkg::FRAME_BYTES) + CW'(row_q) * CW'(3);
    end else begin
      base_d = CW'(frame_number_i) * CW'(rlmsc_pkg::FRAME_BYTES) + CW'(byte_index_i);
    end
  end

  assign addr = ctrl_i.clr_wr ? clr_q : AW'(base_q + CW'(k_q));

  always_comb begin
    case (k_q)
      2'd0:    colour = blue_q;
      2'd1:    colour = red_q;
      default: colour = green_q;
    endcase
  end

  assign mask = 8'd1 << bit_q;

  always_comb begin
    if (ctrl_i.clr_wr) begin
      wdata = '0;
    end else begin
      case (ctrl_i.op)
        rlmsc_pkg::CMD_WR_BYTE:  wdata = data_q;
        rlmsc_pkg::CMD_WR_LINE:  wdata = colour;
        rlmsc_pkg::CMD_WR_PIXEL: wdata = (colour != 8'd0) ? (rdata | mask) : (rdata & ~mask);
        default:                 wdata = '0;
      endcase
    end
  end

  assign we   = ctrl_i.clr_wr || ctrl_i.mem_wr;
  assign show = 7'(level_q) > 7'(phase_q);
  assign word = {word_q, rdata};

  rlmsc_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr),
    .wdata_i (wdata),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q   <= rlmsc_pkg::FRAMES_RESET;
      shown_q <= '0;
      row_q   <= '0;
      phase_q <= '0;
      clr_q   <= '0;
      k_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fiu_q <= cfg_wdata_i;
      end
      if (ctrl_i.clr_wr) begin
        clr_q <= clr_q + AW'(1);
      end
      if (ctrl_i.load) begin
        k_q <= '0;
      end else if (ctrl_i.k_inc) begin
        k_q <= k_q + 2'd1;
      end
      if (ctrl_i.load) begin
        case (cmd)
          rlmsc_pkg::CMD_SEL_FRAME: begin
            if (frame_ok) begin
              shown_q <= FW'(frame_number_i);
            end
          end
          rlmsc_pkg::CMD_NEXT_FRAME: begin
            shown_q <= (shown_inc >= eff) ? '0 : FW'(shown_inc);
          end
          rlmsc_pkg::CMD_RESTART: begin
            shown_q <= '0;
            row_q   <= '0;
            phase_q <= '0;
          end
          default: begin
            shown_q <= shown_q;
          end
        endcase
      end
      if (ctrl_i.emit) begin
        if (row_q == rlmsc_pkg::LAST_ROW) begin
          row_q   <= '0;
          phase_q <= (phase_q >= PW'(LEVELS - 1)) ? '0 : phase_q + PW'(1);
        end else begin
          row_q <= row_q + 3'd1;
        end
      end
      done_q <= ctrl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      base_q  <= base_d;
      bit_q   <= bit_position_i;
      data_q  <= data_byte_i;
      red_q   <= red_value_i;
      green_q <= green_value_i;
      blue_q  <= blue_value_i;
      level_q <= brightness_level_i;
    end
    if (ctrl_i.take) begin
      word_q <= word[15:0];
    end
    if (ctrl_i.emit) begin
      row_drive_q <= rlmsc_pkg::row_drive(row_q);
      shift_q     <= show ? word : 24'd0;
      row_num_q   <= row_q;
    end
  end

  assign done_o       = done_q;
  assign row_drive_o  = row_drive_q;
  assign shift_word_o = shift_q;
  assign row_number_o = row_num_q;

endmodule

@@ hdl/rgb_led_matrix_scan_controller_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_led_matrix_scan_controller_unit
// Draw: done_o rises as busy_o drops, so a new draw can be taken once the last
// is done; it makes three byte reads of the frame store, whose read and write
// ports share one address, each read then taken.
// Write byte writes one byte, write line three, write pixel three by
// read-modify-write per byte; select, next frame and restart take effect at once
// with no busy time. After reset the store is cleared, one byte a cycle, busy
// until all of it is cleared; the result strobe cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`include "rgb_led_matrix_scan_controller_unit_assert.svh"

module rgb_led_matrix_scan_controller_unit #(
  parameter int unsigned MAX_FRAMES = rlmsc_pkg::DEF_MAX_FRAMES,
  parameter int unsigned LEVELS     = rlmsc_pkg::DEF_LEVELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  command_i,
  input  logic [3:0]  frame_number_i,
  input  logic [4:0]  byte_index_i,
  input  logic [2:0]  bit_position_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  red_value_i,
  input  logic [7:0]  green_value_i,
  input  logic [7:0]  blue_value_i,
  input  logic [4:0]  brightness_level_i,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  output logic        done_o,
  output logic [7:0]  row_drive_o,
  output logic [23:0] shift_word_o,
  output logic [2:0]  row_number_o
);

  rlmsc_pkg::ctrl_t ctrl;
  rlmsc_pkg::stat_t stat;

  rlmsc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o)
  );

  rlmsc_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .LEVELS     (LEVELS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .command_i          (command_i),
    .frame_number_i     (frame_number_i),
    .byte_index_i       (byte_index_i),
    .bit_position_i     (bit_position_i),
    .data_byte_i        (data_byte_i),
    .red_value_i        (red_value_i),
    .green_value_i      (green_value_i),
    .blue_value_i       (blue_value_i),
    .brightness_level_i (brightness_level_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .ctrl_i             (ctrl),
    .stat_o             (stat),
    .done_o             (done_o),
    .row_drive_o        (row_drive_o),
    .shift_word_o       (shift_word_o),
    .row_number_o       (row_number_o)
  );

  `RLMSC_ASSERT_NOW(a_drive_onehot, done_o, $onehot(row_drive_o), "row drive not one-hot")
  `RLMSC_ASSERT_NEXT(a_done_single, done_o, !done_o, "result strobe longer than one cycle")
  `RLMSC_ASSERT_NEXT(a_draw_busy, start_i && !busy_o && command_i == 3'(rlmsc_pkg::CMD_DRAW), busy_o, "draw taken without going busy")
  `RLMSC_ASSERT_NOW(a_emit_idle, ctrl.emit, !ctrl.clr_wr && !ctrl.mem_wr, "draw result during a store write")

endmodule
